// ===== hw/rtl/asgr_pkg.sv =====
// Shared types and constants of the SGR escape sequence parser.
`timescale 1ns / 1ps

package asgr_pkg;

  localparam int unsigned MaxSeqLenDefault = 16;
  localparam int unsigned SeqLenW          = 5;
  localparam int unsigned DigitCntW        = 3;
  localparam int unsigned FieldW           = 10;
  localparam int unsigned AttrW            = 8;
  localparam int unsigned ColorMapW        = 32;
  localparam int unsigned CfgDataW         = 32;

  localparam logic [7:0] ChEsc       = 8'h1B;
  localparam logic [7:0] ChBracket   = 8'h5B;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [7:0] ChSemicolon = 8'h3B;
  localparam logic [7:0] ChLowerM    = 8'h6D;
  localparam logic [7:0] ChZero      = 8'h30;

  localparam logic [AttrW-1:0]     DefaultAttrReset = 8'h07;
  localparam logic [ColorMapW-1:0] ColorMapReset    = 32'h7351_6240;

  // Configuration register indexes.
  typedef enum logic {
    CFG_DEFAULT_ATTR = 1'b0,
    CFG_COLOR_MAP    = 1'b1
  } asgr_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_INVALID = 2'd1,
    ST_SUCCESS = 2'd2
  } asgr_status_t;

  typedef struct packed {
    logic [SeqLenW-1:0]   seq_length;
    logic                 private_flag;
    logic                 params_seen;
    logic [DigitCntW-1:0] digit_count;
    logic [FieldW-1:0]    field_value;
    logic                 format_error;
    logic [AttrW-1:0]     pending_attr;
    logic [AttrW-1:0]     display_attr;
  } asgr_state_t;

endpackage

// ===== hw/rtl/ansi_sgr_color_escape_parser.sv =====
// Top level: byte pipeline, configuration registers and parser state.
// A byte accepted into the input register passes the step logic into the result register.
// Throughput: one byte per cycle; the input and result registers are parted by one
// single-pass step, so a stalled result holds the input register only while both are full.
// Reset (rst_n low, synchronous) empties both registers, sets the attribute to 7 and
// the configuration registers to their defaults; no clearing pass follows.
`timescale 1ns / 1ps

module ansi_sgr_color_escape_parser #(
  parameter int unsigned MAX_SEQ_LEN = asgr_pkg::MaxSeqLenDefault
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [asgr_pkg::AttrW-1:0]        out_attribute,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [asgr_pkg::CfgDataW-1:0]     cfg_data
);

  logic                              in_valid_r;
  logic [7:0]                        in_byte_r;
  logic                              out_valid_r;
  logic [1:0]                        out_status_r;
  logic [asgr_pkg::AttrW-1:0]        out_attribute_r;
  logic [asgr_pkg::AttrW-1:0]        default_attr_r;
  logic [asgr_pkg::ColorMapW-1:0]    color_map_r;
  asgr_pkg::asgr_state_t             state_r;
  asgr_pkg::asgr_state_t             state_nxt;
  asgr_pkg::asgr_status_t            step_status;
  asgr_pkg::asgr_state_t             state_reset;
  logic                              advance;
  logic                              in_take;

  asgr_step #(
    .MAX_SEQ_LEN (MAX_SEQ_LEN)
  ) u_step (
    .state        (state_r),
    .byte_in      (in_byte_r),
    .default_attr (default_attr_r),
    .color_map    (color_map_r),
    .state_nxt    (state_nxt),
    .status       (step_status)
  );

  // The held byte moves on whenever the result register is free or being drained.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_attribute = out_attribute_r;

  always_comb begin
    state_reset              = '0;
    state_reset.pending_attr = asgr_pkg::DefaultAttrReset;
    state_reset.display_attr = asgr_pkg::DefaultAttrReset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r        <= state_reset;
      default_attr_r <= asgr_pkg::DefaultAttrReset;
      color_map_r    <= asgr_pkg::ColorMapReset;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          asgr_pkg::CFG_DEFAULT_ATTR: default_attr_r <= cfg_data[asgr_pkg::AttrW-1:0];
          asgr_pkg::CFG_COLOR_MAP:    color_map_r    <= cfg_data[asgr_pkg::ColorMapW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_in;
    end
    if (advance) begin
      out_status_r    <= step_status;
      out_attribute_r <= state_nxt.display_attr;
    end
  end

  // The length counter never reaches the limit.
  a_len_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(state_r.seq_length) < MAX_SEQ_LEN)
    else $error("sequence length reached the limit");

  // The committed attribute moves only on a successful final letter.
  a_commit_on_success: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_status != asgr_pkg::ST_SUCCESS) |=> $stable(state_r.display_attr))
    else $error("attribute changed without success");

  // A pending beat always leaves a sequence in progress.
  a_pending_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && step_status == asgr_pkg::ST_PENDING) |=> state_r.seq_length != '0)
    else $error("pending beat left the parser idle");

  // A result beat carries the committed attribute of the parser.
  a_out_attr: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_attribute_r == state_r.display_attr))
    else $error("result attribute differs from committed attribute");

endmodule

// ===== hw/rtl/asgr_step.sv =====
// Next-state and status logic for one byte of an SGR escape sequence.
`timescale 1ns / 1ps

module asgr_step #(
  parameter int unsigned MAX_SEQ_LEN = asgr_pkg::MaxSeqLenDefault
) (
  input  asgr_pkg::asgr_state_t              state,
  input  logic [7:0]                         byte_in,
  input  logic [asgr_pkg::AttrW-1:0]         default_attr,
  input  logic [asgr_pkg::ColorMapW-1:0]     color_map,
  output asgr_pkg::asgr_state_t              state_nxt,
  output asgr_pkg::asgr_status_t             status
);

  localparam logic [asgr_pkg::SeqLenW-1:0] LenLast =
    asgr_pkg::SeqLenW'(MAX_SEQ_LEN - 1);

  function automatic logic [asgr_pkg::AttrW-1:0] apply_code(
    input logic [asgr_pkg::AttrW-1:0]     attr,
    input logic [asgr_pkg::FieldW-1:0]    code,
    input logic [asgr_pkg::AttrW-1:0]     dflt,
    input logic [asgr_pkg::ColorMapW-1:0] cmap
  );
    logic [3:0] fg;
    logic [3:0] bg;
    logic [asgr_pkg::FieldW-1:0] fg_off;
    logic [asgr_pkg::FieldW-1:0] bg_off;
    fg     = attr[3:0];
    bg     = attr[7:4];
    fg_off = code - asgr_pkg::FieldW'(30);
    bg_off = code - asgr_pkg::FieldW'(40);
    if (code inside {[10'd30:10'd37]}) begin
      // The bright bit of the old color survives a color change.
      fg = cmap[{fg_off[2:0], 2'b00} +: 4] | {fg[3], 3'b000};
    end else if (code == 10'd39) begin
      fg = dflt[3:0];
    end else if (code inside {[10'd40:10'd47]}) begin
      bg = cmap[{bg_off[2:0], 2'b00} +: 4] | {bg[3], 3'b000};
    end else if (code == 10'd49) begin
      bg = dflt[7:4];
    end else if (code == 10'd7) begin
      fg = attr[7:4];
      bg = attr[3:0];
    end else if (code == 10'd0) begin
      fg = dflt[3:0];
      bg = dflt[7:4];
    end else if (code == 10'd1) begin
      fg = fg | 4'h8;
      bg = bg | 4'h8;
    end
    return {bg, fg};
  endfunction

  logic                          is_alpha;
  logic                          is_digit;
  logic                          field_live;
  logic [asgr_pkg::AttrW-1:0]    fin_attr;
  logic [asgr_pkg::FieldW-1:0]   field_acc;
  logic [7:0]                    digit_val;
  asgr_pkg::asgr_state_t         cleared;
  asgr_pkg::asgr_state_t         body;

  assign is_alpha   = byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_digit   = byte_in inside {[8'h30:8'h39]};
  assign field_live = (state.digit_count != '0) && (state.digit_count <= 3'd3);
  assign fin_attr   = field_live ?
                      apply_code(state.pending_attr, state.field_value, default_attr, color_map) :
                      state.pending_attr;
  assign digit_val  = byte_in - asgr_pkg::ChZero;
  assign field_acc  = asgr_pkg::FieldW'(state.field_value * asgr_pkg::FieldW'(10))
                      + asgr_pkg::FieldW'(digit_val[3:0]);

  always_comb begin
    cleared              = '0;
    cleared.pending_attr = state.display_attr;
    cleared.display_attr = state.display_attr;

    body       = state;
    state_nxt  = state;
    status     = asgr_pkg::ST_PENDING;

    if (state.seq_length == '0) begin
      state_nxt = cleared;
      if (byte_in != asgr_pkg::ChEsc) begin
        status = asgr_pkg::ST_INVALID;
      end else begin
        state_nxt.seq_length = asgr_pkg::SeqLenW'(1);
      end
    end else if (state.seq_length == asgr_pkg::SeqLenW'(1)) begin
      if (byte_in != asgr_pkg::ChBracket) begin
        state_nxt = cleared;
        status    = asgr_pkg::ST_INVALID;
      end else begin
        state_nxt.seq_length = asgr_pkg::SeqLenW'(2);
      end
    end else if (is_alpha) begin
      if (state.format_error || byte_in != asgr_pkg::ChLowerM) begin
        state_nxt = cleared;
        status    = asgr_pkg::ST_INVALID;
      end else begin
        state_nxt              = cleared;
        state_nxt.pending_attr = fin_attr;
        state_nxt.display_attr = fin_attr;
        status                 = asgr_pkg::ST_SUCCESS;
      end
    end else if (is_digit || byte_in == asgr_pkg::ChSemicolon ||
                 (byte_in == asgr_pkg::ChQuestion && !state.params_seen)) begin
      if (is_digit) begin
        if (state.digit_count < 3'd3) begin
          body.field_value = field_acc;
        end
        if (state.digit_count < 3'd4) begin
          body.digit_count = state.digit_count + 3'd1;
        end
        if (state.digit_count >= 3'd3) begin
          body.format_error = 1'b1;
        end
      end else if (byte_in == asgr_pkg::ChSemicolon) begin
        body.pending_attr = fin_attr;
        body.digit_count  = '0;
        body.field_value  = '0;
      end else begin
        body.private_flag = 1'b1;
      end
      // A body byte that reaches the length limit kills the sequence.
      if (state.seq_length >= LenLast) begin
        state_nxt = cleared;
        status    = asgr_pkg::ST_INVALID;
      end else begin
        state_nxt             = body;
        state_nxt.seq_length  = state.seq_length + asgr_pkg::SeqLenW'(1);
        state_nxt.params_seen = 1'b1;
      end
    end else begin
      state_nxt = cleared;
      status    = asgr_pkg::ST_INVALID;
    end
  end

endmodule
